@@ design/assert_macros.svh @@
// Assertion macros used by the top-level encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`else

`define ASSERT_AT(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

@@ design/fxdrle_pkg.sv @@
// Types and constants of the XOR-delta run-length encoder.
`default_nettype none
package fxdrle_pkg;

	localparam int MAX_FRAME_WORDS = 2097152;
	localparam int ADDR_W = $clog2(MAX_FRAME_WORDS);
	localparam int FILL_W = ADDR_W + 1;
	localparam int CFG_W = 22;
	localparam int WORD_W = 32;
	localparam int RUN_W = 31;
	localparam int TOTAL_W = 22;

	localparam logic [RUN_W-1:0] RUN_CAP = RUN_W'(1) << 30;
	localparam logic [CFG_W-1:0] FRAME_WORDS_RESET = CFG_W'(MAX_FRAME_WORDS);
	localparam logic [CFG_W-1:0] DELTA_LIMIT_RESET = CFG_W'(100000);

	// register index, taken from paddr[2]
	typedef enum logic [0:0] {
		REG_FRAME_WORDS = 1'b0,
		REG_DELTA_LIMIT = 1'b1
	} reg_idx_t;

	// output queue
	localparam int OUT_DEPTH = 8;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = OUT_PTR_W + 1;
	localparam int MAX_PUSH = 3;

	typedef struct packed {
		logic               last;
		logic               keyframe_advised;
		logic [TOTAL_W-1:0] delta_total;
		logic [WORD_W-1:0]  run_value;
		logic [RUN_W-1:0]   run_count;
	} rec_t;

	// records pushed in one cycle: rec[0] first, cnt of them valid
	typedef struct packed {
		logic [1:0]          cnt;
		rec_t [MAX_PUSH-1:0] rec;
	} push_t;

endpackage
`default_nettype wire

@@ design/fxdrle_store.sv @@
// Frame store: one-port-read, one-port-write synchronous RAM of the previous frame.
`default_nettype none
module fxdrle_store (
	input  wire logic                        clk,
	input  wire logic                        rd_en,
	input  wire logic [fxdrle_pkg::ADDR_W-1:0] rd_addr,
	output logic      [fxdrle_pkg::WORD_W-1:0] rd_data,
	input  wire logic                        wr_en,
	input  wire logic [fxdrle_pkg::ADDR_W-1:0] wr_addr,
	input  wire logic [fxdrle_pkg::WORD_W-1:0] wr_data
);
	import fxdrle_pkg::*;

	logic [WORD_W-1:0] mem [MAX_FRAME_WORDS];

	// read returns the old word when the same entry is written in that cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule
`default_nettype wire

@@ design/fxdrle_fifo.sv @@
// Output record queue taking up to three records per cycle.
`default_nettype none
module fxdrle_fifo (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire fxdrle_pkg::push_t             push,
	output fxdrle_pkg::rec_t                   head,
	output logic                               head_valid,
	input  wire logic                          pop,
	output logic [fxdrle_pkg::OUT_CNT_W-1:0]   count
);
	import fxdrle_pkg::*;

	rec_t                 mem_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0] count_q;
	logic                 do_pop;

	assign do_pop     = pop && (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign count      = count_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_PUSH; i++) begin
			if (2'(i) < push.cnt) begin
				mem_q[wr_ptr_q + OUT_PTR_W'(i)] <= push.rec[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(push.cnt);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			count_q <= count_q + OUT_CNT_W'(push.cnt) - OUT_CNT_W'(do_pop);
		end
	end

endmodule
`default_nettype wire

@@ design/frame_xor_delta_rle_encoder.sv @@
// Top level of the XOR-delta run-length encoder for framebuffer words.
`default_nettype none
// Takes one 32-bit pixel word per beat in raster order, XORs it with the word at
// the same position of the previous frame and run-length encodes the differences.
// The frame store is read in the cycle the beat is accepted, and the difference,
// the run update and the write-back happen in the next; its records enter the
// output queue at the end of that cycle and can leave on the one after. A new
// word can be taken every cycle while the queue has room, with a
// write-back/read collision on the same entry (one-word frames) resolved by
// forwarding. Records go through an eight-entry queue and one word can add up to
// three of them, so the input is held off while the queue holds more than two
// records with a word in the second stage, or more than five otherwise; a burst of
// frame-end records can hold off input even with the output always ready. The
// frame store needs no clearing pass after reset: a fill mark tracks how far the
// store has been written, and entries beyond it read as zero.
// Registers (APB): 0x0 frame_words, 0x4 delta_limit; write them while idle.
module frame_xor_delta_rle_encoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave stream: [31:0] pixel_word
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,
	// master stream: [30:0] run_count, [62:31] run_value, [84:63] delta_total,
	// [85] keyframe_advised, [87:86] zero
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [87:0]      m_axis_tdata,
	output logic             m_axis_tlast,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import fxdrle_pkg::*;

	// config registers
	logic [CFG_W-1:0] frame_words_q;
	logic [CFG_W-1:0] delta_limit_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_words_q <= FRAME_WORDS_RESET;
			delta_limit_q <= DELTA_LIMIT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_FRAME_WORDS: frame_words_q <= pwdata[CFG_W-1:0];
				REG_DELTA_LIMIT: delta_limit_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr[2])
			REG_FRAME_WORDS: prdata = 32'(frame_words_q);
			REG_DELTA_LIMIT: prdata = 32'(delta_limit_q);
			default: prdata = '0;
		endcase
	end

	// ---------------- stage 0: accept, position, store read ----------------
	logic [ADDR_W-1:0]    word_position_q;
	logic [FILL_W-1:0]    fill_q;
	logic [ADDR_W-1:0]    last_pos;
	logic                 in_acc;
	logic                 end_s0;
	logic                 fresh_s0;
	logic                 fwd_s0;
	logic [OUT_CNT_W-1:0] fifo_count;
	logic [OUT_CNT_W:0]   room_need;

	logic                 valid_s1;
	logic [ADDR_W-1:0]    pos_s1;
	logic [WORD_W-1:0]    word_s1;
	logic                 start_s1;
	logic                 end_s1;
	logic                 fresh_s1;
	logic                 fwd_s1;
	logic [WORD_W-1:0]    fwd_word_s1;

	always_comb begin
		if (frame_words_q == '0) begin
			last_pos = '0;
		end else if (frame_words_q > CFG_W'(MAX_FRAME_WORDS)) begin
			last_pos = ADDR_W'(MAX_FRAME_WORDS - 1);
		end else begin
			last_pos = ADDR_W'(frame_words_q - CFG_W'(1));
		end
	end

	// worst case: the word in stage 1 and the new one each push three records
	assign room_need     = (OUT_CNT_W+1)'(fifo_count)
		+ (valid_s1 ? (OUT_CNT_W+1)'(MAX_PUSH) : '0);
	assign s_axis_tready = room_need <= (OUT_CNT_W+1)'(OUT_DEPTH - MAX_PUSH);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign end_s0        = word_position_q >= last_pos;
	// positions are written as a prefix, so only the fill edge is unwritten
	assign fresh_s0      = (FILL_W'(word_position_q) == fill_q);
	assign fwd_s0        = valid_s1 && (pos_s1 == word_position_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_position_q <= '0;
			fill_q          <= '0;
			valid_s1        <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
			if (in_acc) begin
				word_position_q <= end_s0 ? '0 : word_position_q + ADDR_W'(1);
				if (fresh_s0) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pos_s1      <= word_position_q;
			word_s1     <= s_axis_tdata;
			start_s1    <= (word_position_q == '0);
			end_s1      <= end_s0;
			fresh_s1    <= fresh_s0;
			fwd_s1      <= fwd_s0;
			fwd_word_s1 <= word_s1;
		end
	end

	logic [WORD_W-1:0] rd_data;

	fxdrle_store u_store (
		.clk     (clk),
		.rd_en   (in_acc),
		.rd_addr (word_position_q),
		.rd_data (rd_data),
		.wr_en   (valid_s1),
		.wr_addr (pos_s1),
		.wr_data (word_s1)
	);

	// ---------------- stage 1: difference, run update, write-back ----------------
	logic [WORD_W-1:0]  run_val_q;
	logic [RUN_W-1:0]   run_len_q;
	logic [TOTAL_W-1:0] nz_q;

	logic [WORD_W-1:0]  prev_word;
	logic [WORD_W-1:0]  diff;
	logic [TOTAL_W-1:0] nz_new;
	logic [WORD_W-1:0]  val_new;
	logic [RUN_W-1:0]   len_new;
	logic               close_run;
	logic               advised;
	rec_t               closed_rec;
	rec_t               final_rec;
	rec_t               term_rec;
	push_t              push;

	always_comb begin
		if (fwd_s1) begin
			prev_word = fwd_word_s1;
		end else if (fresh_s1) begin
			prev_word = '0;
		end else begin
			prev_word = rd_data;
		end
		diff = word_s1 ^ prev_word;

		nz_new = nz_q;
		if (diff != '0 && nz_q != '1) begin
			nz_new = nz_q + TOTAL_W'(1);
		end

		close_run = 1'b0;
		if (start_s1) begin
			val_new = diff;
			len_new = RUN_W'(1);
		end else if (diff == run_val_q && run_len_q <= RUN_CAP) begin
			val_new = run_val_q;
			len_new = run_len_q + RUN_W'(1);
		end else begin
			close_run = 1'b1;
			val_new   = diff;
			len_new   = RUN_W'(1);
		end

		advised = nz_new >= delta_limit_q;

		closed_rec = '{last: 1'b0, keyframe_advised: 1'b0, delta_total: '0,
			run_value: run_val_q, run_count: run_len_q};
		final_rec  = '{last: 1'b0, keyframe_advised: 1'b0, delta_total: '0,
			run_value: val_new, run_count: len_new};
		term_rec   = '{last: 1'b1, keyframe_advised: advised, delta_total: nz_new,
			run_value: '0, run_count: '0};

		push.rec[0] = close_run ? closed_rec : final_rec;
		push.rec[1] = close_run ? final_rec : term_rec;
		push.rec[2] = term_rec;
		if (!valid_s1) begin
			push.cnt = 2'd0;
		end else if (end_s1) begin
			push.cnt = close_run ? 2'd3 : 2'd2;
		end else begin
			push.cnt = close_run ? 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_val_q <= '0;
			run_len_q <= '0;
			nz_q      <= '0;
		end else if (valid_s1) begin
			if (end_s1) begin
				run_val_q <= '0;
				run_len_q <= '0;
				nz_q      <= '0;
			end else begin
				run_val_q <= val_new;
				run_len_q <= len_new;
				nz_q      <= nz_new;
			end
		end
	end

	// ---------------- output ----------------
	rec_t head;
	logic head_valid;

	fxdrle_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.head       (head),
		.head_valid (head_valid),
		.pop        (m_axis_tready),
		.count      (fifo_count)
	);

	assign m_axis_tvalid = head_valid;
	assign m_axis_tlast  = head.last;
	assign m_axis_tdata  = {2'b00, head.keyframe_advised, head.delta_total,
		head.run_value, head.run_count};

	`include "assert_macros.svh"

	`ASSERT_AT(a_fwd_only_behind_s1, clk, arst_n, (in_acc && fwd_s0) |-> valid_s1, "stray forward")
	`ASSERT_AT(a_fill_prefix, clk, arst_n, in_acc |-> (FILL_W'(word_position_q) <= fill_q), "past fill")
	`ASSERT_AT(a_frame_wrap, clk, arst_n, (in_acc && end_s0) |=> (word_position_q == '0), "no wrap")
	`ASSERT_NEVER(a_queue_overflow, clk, arst_n, fifo_count > OUT_CNT_W'(OUT_DEPTH), "queue overflow")

endmodule
`default_nettype wire
